/* src/vtae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtae_pkg
// Shared types and constants of the vehicle threshold alert engine.
// ----------------------------------------------------------------------------
package vtae_pkg;

    // Register index width and register indexes of the configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_GAS_CLEAR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAS_ALARM   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAS_HIGH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_FIRST = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_STEP  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_HYST  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WARM        = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERHEAT    = 3'd7;

    // Alert codes
    localparam int CODE_W          = 4;
    localparam int CODE_GAS_LOW    = 0;
    localparam int CODE_GAS_HIGH   = 1;
    localparam int CODE_SPEED_BASE = 2;
    localparam int CODE_WARM       = 11;
    localparam int CODE_OVERHEAT   = 12;
    localparam int NUM_CODES       = 13;

    // Codes 2..10 hold at most nine speed levels
    localparam int MAX_SPEED_LEVELS = 9;

    // Fixed temperature clear levels
    localparam logic signed [8:0] WARM_CLEAR     = 9'sd35;
    localparam logic signed [8:0] OVERHEAT_CLEAR = 9'sd95;

    // One bit per alert code, bit position equals the code
    typedef logic [NUM_CODES-1:0] t_alert_mask;

    // Configuration register file
    typedef struct packed {
        logic [9:0]        gas_clear;
        logic [9:0]        gas_alarm;
        logic [9:0]        gas_high;
        logic [7:0]        speed_first;
        logic [6:0]        speed_step;
        logic [5:0]        speed_hyst;
        logic signed [8:0] warm_level;
        logic signed [8:0] overheat_level;
    } t_cfg;

    // One sensor poll
    typedef struct packed {
        logic signed [8:0] coolant_temp;
        logic [9:0]        gas_reading;
        logic [7:0]        speed_kmh;
    } t_poll;

endpackage

/* src/vehicle_threshold_alert_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path: a poll passes the input register, then the result register, from which
// its first alert is offered on the alert stream.
// Throughput: one poll per cycle while polls raise at most one alert and the
// output is ready; a poll with more alerts (up to twelve) holds it until all are taken.
// Reset: synchronous active low; clears all alert flags and the gas timer and
// loads the default thresholds.
// ----------------------------------------------------------------------------
// vehicle_threshold_alert_engine
// Sensor poll alert engine: gas repeat alarm, latched speed levels and
// temperature alerts, delivered as a stream of alert codes.
// ----------------------------------------------------------------------------
module vehicle_threshold_alert_engine
    import vtae_pkg::*;
#(
    parameter int NUM_SPEED_LEVELS = 9,
    parameter int GAS_REPEAT       = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // poll stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,  // speed_kmh[7:0], gas_reading[17:8],
                                              // coolant_temp[26:18], zero[31:27]
    // alert stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,  // alert_code[3:0], zero[7:4]
    output logic                  o_m_tlast   // last_alert
);

    localparam int ACTIVE_LEVELS =
        (NUM_SPEED_LEVELS > MAX_SPEED_LEVELS) ? MAX_SPEED_LEVELS : NUM_SPEED_LEVELS;

    t_cfg                     r_cfg;
    t_poll                    r_poll;
    logic                     r_poll_vld;
    t_alert_mask              r_mask;
    logic                     r_mask_vld;
    logic [5:0]               r_gas_timer;
    logic [ACTIVE_LEVELS-1:0] r_speed_ann;
    logic                     r_warm_ann;
    logic                     r_over_ann;

    logic [5:0]               n_gas_timer;
    logic [ACTIVE_LEVELS-1:0] n_speed_ann;
    logic                     n_warm_ann;
    logic                     n_over_ann;
    t_alert_mask              n_mask;

    logic                     s_fire;
    logic                     m_fire;
    logic                     m_last;
    logic                     mask_free;
    logic                     adv;
    logic [CODE_W-1:0]        code;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gas_clear      <= 10'd50;
            r_cfg.gas_alarm      <= 10'd70;
            r_cfg.gas_high       <= 10'd150;
            r_cfg.speed_first    <= 8'd60;
            r_cfg.speed_step     <= 7'd10;
            r_cfg.speed_hyst     <= 6'd5;
            r_cfg.warm_level     <= 9'sd40;
            r_cfg.overheat_level <= 9'sd98;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_GAS_CLEAR:   r_cfg.gas_clear      <= i_cfg_data;
                REG_GAS_ALARM:   r_cfg.gas_alarm      <= i_cfg_data;
                REG_GAS_HIGH:    r_cfg.gas_high       <= i_cfg_data;
                REG_SPEED_FIRST: r_cfg.speed_first    <= i_cfg_data[7:0];
                REG_SPEED_STEP:  r_cfg.speed_step     <= i_cfg_data[6:0];
                REG_SPEED_HYST:  r_cfg.speed_hyst     <= i_cfg_data[5:0];
                REG_WARM:        r_cfg.warm_level     <= i_cfg_data[8:0];
                REG_OVERHEAT:    r_cfg.overheat_level <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Handshake control
    assign m_fire     = r_mask_vld & i_m_tready;
    assign m_last     = ((r_mask & (r_mask - t_alert_mask'(1))) == '0);
    assign mask_free  = !r_mask_vld || (m_fire && m_last);
    assign adv        = r_poll_vld && mask_free;
    assign o_s_tready = !r_poll_vld || adv;
    assign s_fire     = i_s_tvalid & o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_vld <= 1'b0;
        end else if (s_fire) begin
            r_poll_vld <= 1'b1;
        end else if (adv) begin
            r_poll_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_poll <= i_s_tdata[26:0];
        end
    end

    // Alert evaluation
    vtae_eval #(
        .NUM_LEVELS (ACTIVE_LEVELS),
        .GAS_REPEAT (GAS_REPEAT)
    ) u_eval (
        .i_cfg       (r_cfg),
        .i_poll      (r_poll),
        .i_gas_timer (r_gas_timer),
        .i_speed_ann (r_speed_ann),
        .i_warm_ann  (r_warm_ann),
        .i_over_ann  (r_over_ann),
        .o_gas_timer (n_gas_timer),
        .o_speed_ann (n_speed_ann),
        .o_warm_ann  (n_warm_ann),
        .o_over_ann  (n_over_ann),
        .o_mask      (n_mask)
    );

    // Alert state: commit when the poll moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_timer <= '0;
            r_speed_ann <= '0;
            r_warm_ann  <= 1'b0;
            r_over_ann  <= 1'b0;
        end else if (adv) begin
            r_gas_timer <= n_gas_timer;
            r_speed_ann <= n_speed_ann;
            r_warm_ann  <= n_warm_ann;
            r_over_ann  <= n_over_ann;
        end
    end

    // Result register: load a poll's alerts, drop the lowest on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_vld <= 1'b0;
        end else if (adv) begin
            r_mask_vld <= (n_mask != '0);
        end else if (m_fire) begin
            r_mask_vld <= !m_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mask <= n_mask;
        end else if (m_fire) begin
            r_mask <= r_mask & (r_mask - t_alert_mask'(1));
        end
    end

    // Pick the lowest pending code
    always_comb begin
        code = '0;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                code = CODE_W'(k);
            end
        end
    end

    assign o_m_tvalid = r_mask_vld;
    assign o_m_tdata  = {4'b0000, code};
    assign o_m_tlast  = m_last;

endmodule

/* src/vtae_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtae_eval
// Evaluates one poll against the alert state: returns the set of alerts the
// poll raises and the next value of every alert flag and the gas timer.
// ----------------------------------------------------------------------------
module vtae_eval
    import vtae_pkg::*;
#(
    parameter int NUM_LEVELS = 9,
    parameter int GAS_REPEAT = 50
) (
    input  t_cfg                  i_cfg,
    input  t_poll                 i_poll,
    input  logic [5:0]            i_gas_timer,
    input  logic [NUM_LEVELS-1:0] i_speed_ann,
    input  logic                  i_warm_ann,
    input  logic                  i_over_ann,
    output logic [5:0]            o_gas_timer,
    output logic [NUM_LEVELS-1:0] o_speed_ann,
    output logic                  o_warm_ann,
    output logic                  o_over_ann,
    output t_alert_mask           o_mask
);

    logic [10:0]           lvl [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] rearm;
    logic [NUM_LEVELS-1:0] clr;
    logic [5:0]            gt;
    logic [10:0]           spd_hyst;
    logic                  warm_tmp;
    logic                  over_tmp;
    logic                  temp_seen;

    // Speed levels without wrap (top level reaches 255 + 8 * 127)
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl[i] = {3'b000, i_cfg.speed_first} + 11'(i) * {4'b0000, i_cfg.speed_step};
        end
    end

    assign spd_hyst  = {3'b000, i_poll.speed_kmh} + {5'b00000, i_cfg.speed_hyst};
    assign temp_seen = (i_poll.coolant_temp != 9'sd0);

    always_comb begin
        o_mask = '0;

        // Gas repeat timer
        gt = i_gas_timer;
        if (gt != 6'd0) begin
            gt = gt + 6'd1;
        end
        if (i_poll.gas_reading < i_cfg.gas_clear) begin
            gt = 6'd0;
        end
        if (gt == 6'(GAS_REPEAT)) begin
            gt = 6'd0;
        end
        if (i_poll.gas_reading >= i_cfg.gas_alarm) begin
            if (gt == 6'd0) begin
                gt = 6'd1;
            end
            if (gt == 6'd1) begin
                if (i_poll.gas_reading < i_cfg.gas_high) begin
                    o_mask[CODE_GAS_LOW] = 1'b1;
                end else begin
                    o_mask[CODE_GAS_HIGH] = 1'b1;
                end
            end
        end
        o_gas_timer = gt;

        // Speed re-arm: a level that re-arms clears itself and all above
        for (int i = 0; i < NUM_LEVELS; i++) begin
            rearm[i] = (i_poll.speed_kmh != 8'd0) && (spd_hyst < lvl[i]);
        end
        clr[0] = rearm[0];
        for (int i = 1; i < NUM_LEVELS; i++) begin
            clr[i] = clr[i-1] | rearm[i];
        end

        // Speed fire
        for (int i = 0; i < NUM_LEVELS; i++) begin
            o_speed_ann[i] = i_speed_ann[i] & ~clr[i];
            if (!o_speed_ann[i] && ({3'b000, i_poll.speed_kmh} > lvl[i])) begin
                o_speed_ann[i]              = 1'b1;
                o_mask[CODE_SPEED_BASE + i] = 1'b1;
            end
        end

        // Temperature re-arm, then fire
        warm_tmp = i_warm_ann;
        over_tmp = i_over_ann;
        if (temp_seen) begin
            if (i_poll.coolant_temp < WARM_CLEAR) begin
                warm_tmp = 1'b0;
                over_tmp = 1'b0;
            end
            if (i_poll.coolant_temp < OVERHEAT_CLEAR) begin
                over_tmp = 1'b0;
            end
        end
        if (!warm_tmp && (i_poll.coolant_temp > i_cfg.warm_level)) begin
            warm_tmp          = 1'b1;
            o_mask[CODE_WARM] = 1'b1;
        end
        if (!over_tmp && (i_poll.coolant_temp > i_cfg.overheat_level)) begin
            over_tmp              = 1'b1;
            o_mask[CODE_OVERHEAT] = 1'b1;
        end
        o_warm_ann = warm_tmp;
        o_over_ann = over_tmp;
    end

endmodule
